@@ src/double_hash_table_macros.svh @@
// ----------------------------------------------------------------------------
// double_hash_table_macros.svh
// Assertion macros shared by the checker of the double-hashing table.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_TABLE_MACROS_SVH
`define DOUBLE_HASH_TABLE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define DHT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define DHT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/dht_pkg.sv @@
// ----------------------------------------------------------------------------
// dht_pkg
// Types, codes and constants shared by the double-hashing table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dht_pkg;

   localparam int TABLE_SIZE_DEF = 16;
   localparam int KEY_W          = 31;
   localparam int SLOT_OUT_W     = 4;
   localparam int STEP_BASE      = 7;
   localparam int STEP_W         = 3;
   // key is reduced a digit at a time, padded to a whole number of digits
   localparam int DIGIT_W        = 4;
   localparam int HASH_W         = 32;
   localparam int HASH_STEPS     = HASH_W / DIGIT_W;
   localparam int HASH_CNT_W     = $clog2(HASH_STEPS);

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_FOUND     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_SEED,
      ST_READ,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic       load;
      logic       hash;
      logic       seed;
      logic       clear;
      logic       rd;
      logic       adv;
      logic       wr;
      logic       rsp_load;
      logic       rsp_hit;
      status_type rsp_status;
   } dht_cmd_type;

   typedef struct packed {
      logic hash_last;
      logic clear_last;
      logic probe_last;
      logic mode;
      logic used;
      logic match;
      logic rsp_free;
   } dht_stat_type;

endpackage

`default_nettype wire

@@ src/dht_dpath.sv @@
// ----------------------------------------------------------------------------
// dht_dpath
// Datapath: key reduction, probe walk, slot memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_dpath
   import dht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dht_cmd_type           cmd,
   output dht_stat_type               stat,
   input  wire logic                  req_mode,
   input  wire logic [KEY_W-1:0]      req_key,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [SLOT_OUT_W-1:0]      rsp_slot
);

   localparam int SLOT_W = $clog2(TABLE_SIZE);
   localparam logic [SLOT_W:0]   SIZE_WIDE = (SLOT_W + 1)'(TABLE_SIZE);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
   localparam logic [STEP_W:0]   BASE_WIDE = (STEP_W + 1)'(STEP_BASE);

   // request capture and key reduction
   logic                  mode_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [HASH_W-1:0]     shift_ff, shift_in;
   logic [HASH_CNT_W-1:0] dig_ff, dig_in;
   logic [SLOT_W-1:0]     rem_n_ff, rem_n_in;
   logic [STEP_W-1:0]     rem7_ff, rem7_in;
   logic [SLOT_W:0]       t_n;
   logic [STEP_W:0]       t_7;

   // probe walk
   logic [SLOT_W-1:0]     cur_ff, cur_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SLOT_W-1:0]     cnt_ff, cnt_in;
   logic [SLOT_W:0]       sum;

   // clearing pass
   logic [SLOT_W-1:0]     clr_ff, clr_in;

   // slot memory: used bit on top of the key
   logic [KEY_W:0]        mem [TABLE_SIZE];
   logic [KEY_W:0]        rd_ff;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_addr;
   logic [KEY_W:0]        mem_wdata;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            status_ff;
   logic [SLOT_OUT_W-1:0] slot_ff;
   logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

   // one digit of key mod TABLE_SIZE and key mod 7 per cycle
   always_comb begin
      rem_n_in = rem_n_ff;
      rem7_in  = rem7_ff;
      t_n      = '0;
      t_7      = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         t_n = {rem_n_in, shift_ff[HASH_W-1-i]};
         if (t_n >= SIZE_WIDE) begin
            t_n = t_n - SIZE_WIDE;
         end
         rem_n_in = t_n[SLOT_W-1:0];
         t_7 = {rem7_in, shift_ff[HASH_W-1-i]};
         if (t_7 >= BASE_WIDE) begin
            t_7 = t_7 - BASE_WIDE;
         end
         rem7_in = t_7[STEP_W-1:0];
      end
      if (cmd.load) begin
         rem_n_in = '0;
         rem7_in  = '0;
      end
   end

   assign shift_in = cmd.load ? {1'b0, req_key} : (shift_ff << DIGIT_W);
   assign dig_in   = cmd.load ? '0 : dig_ff + 1'b1;

   // next slot on the probe path; step is below the table size
   always_comb begin
      sum = {1'b0, cur_ff} + {{(SLOT_W - STEP_W + 1){1'b0}}, step_ff};
      if (sum >= SIZE_WIDE) begin
         sum = sum - SIZE_WIDE;
      end
   end

   assign cur_in  = cmd.seed ? rem_n_ff : sum[SLOT_W-1:0];
   assign step_in = STEP_W'(BASE_WIDE - {1'b0, rem7_ff});
   assign cnt_in  = cmd.seed ? '0 : cnt_ff + 1'b1;
   assign clr_in  = clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
      end
      if (cmd.load || cmd.hash) begin
         shift_ff <= shift_in;
         rem_n_ff <= rem_n_in;
         rem7_ff  <= rem7_in;
      end
      if (cmd.seed) begin
         step_ff <= step_in;
      end
      if (cmd.seed || cmd.adv) begin
         cur_ff <= cur_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dig_ff <= '0;
         clr_ff <= '0;
      end else begin
         if (cmd.load || cmd.hash) begin
            dig_ff <= dig_in;
         end
         if (cmd.clear) begin
            clr_ff <= clr_in;
         end
      end
   end

   // memory port: clearing pass or insert
   assign mem_we    = cmd.clear || cmd.wr;
   assign mem_addr  = cmd.clear ? clr_ff : cur_ff;
   assign mem_wdata = cmd.clear ? '0 : {1'b1, key_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.rd) begin
         rd_ff <= mem[cur_ff];
      end
   end

   // result register
   assign slot_ext     = {{SLOT_OUT_W{1'b0}}, cur_ff};
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff <= cmd.rsp_status;
         slot_ff   <= cmd.rsp_hit ? slot_ext[SLOT_OUT_W-1:0] : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_slot   = slot_ff;

   assign stat.hash_last  = (dig_ff == HASH_CNT_W'(HASH_STEPS - 1));
   assign stat.clear_last = (clr_ff == LAST_SLOT);
   assign stat.probe_last = (cnt_ff == LAST_SLOT);
   assign stat.mode       = mode_ff;
   assign stat.used       = rd_ff[KEY_W];
   assign stat.match      = (rd_ff[KEY_W-1:0] == key_ff);
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

@@ src/dht_ctrl.sv @@
// ----------------------------------------------------------------------------
// dht_ctrl
// Controller: clearing pass, key reduction, probe sequencing and outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_ctrl
   import dht_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   output dht_cmd_type       cmd,
   input  wire dht_stat_type stat
);

   state_type  state_ff, state_in;
   logic       fin;
   logic       fin_hit;
   logic       fin_wr;
   status_type fin_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      fin        = 1'b0;
      fin_hit    = 1'b0;
      fin_wr     = 1'b0;
      fin_status = STATUS_NOT_FOUND;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash = 1'b1;
            if (stat.hash_last) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.mode == MODE_INSERT) begin
               if (!stat.used) begin
                  fin        = 1'b1;
                  fin_hit    = 1'b1;
                  fin_wr     = 1'b1;
                  fin_status = STATUS_INSERTED;
               end else if (stat.probe_last) begin
                  fin        = 1'b1;
                  fin_status = STATUS_FULL;
               end
            end else begin
               if (!stat.used) begin
                  fin        = 1'b1;
                  fin_status = STATUS_NOT_FOUND;
               end else if (stat.match) begin
                  fin        = 1'b1;
                  fin_hit    = 1'b1;
                  fin_status = STATUS_FOUND;
               end else if (stat.probe_last) begin
                  fin        = 1'b1;
                  fin_status = STATUS_NOT_FOUND;
               end
            end
            if (!fin) begin
               cmd.adv  = 1'b1;
               state_in = ST_READ;
            end else if (stat.rsp_free) begin
               // hold here until the result register has room
               cmd.rsp_load   = 1'b1;
               cmd.rsp_hit    = fin_hit;
               cmd.rsp_status = fin_status;
               cmd.wr         = fin_wr;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/double_hash_table.sv @@
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressed hash table of 31-bit keys with double hashing.
// ----------------------------------------------------------------------------
// Each item inserts (mode 0) or searches for (mode 1) one key. The home slot
// is key mod TABLE_SIZE and the probe step is 7 - (key mod 7); probe i visits
// (home + i * step) mod TABLE_SIZE, at most TABLE_SIZE probes per item. An
// insert takes the first empty slot (duplicates are kept) or reports table
// full; a search stops at a matching key (found) or an empty slot (not
// found). Status codes: 0 inserted, 1 table full, 2 found, 3 not found; slot
// carries the low 4 bits of the slot index, 0 for full and not found.
// One item is worked on at a time. An item is accepted, its key is reduced
// four key bits a cycle through the mod TABLE_SIZE and mod 7 remainder
// units, the probe is seeded, and each probe is a registered read of the
// slot memory followed by a compare. The result sits in an output register,
// and the next item is taken while it waits. After reset the block clears
// the slot memory one entry a cycle and holds req_stall high until the
// clearing pass is done.
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_table
   import dht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_mode,
   input  wire logic [KEY_W-1:0]      req_key,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [SLOT_OUT_W-1:0]      rsp_slot
);

   // commands from the controller, status back from the datapath
   dht_cmd_type  cmd;
   dht_stat_type stat;

   // sequence clearing, key reduction and probes
   dht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // hold the key, walk the probe path, own the memory and result register
   dht_dpath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_mode   (req_mode),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

endmodule

`default_nettype wire

@@ src/dht_checker.sv @@
// ----------------------------------------------------------------------------
// dht_checker
// Port-level checks of the double-hashing table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_hash_table_macros.svh"

module dht_checker
   import dht_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [1:0]            rsp_status,
   input wire logic [SLOT_OUT_W-1:0] rsp_slot
);

   logic                           rsp_wait;
   logic                           rsp_miss;
   logic [SLOT_OUT_W+1:0]          rsp_payload;

   assign rsp_wait    = rsp_valid && rsp_stall;
   assign rsp_miss    = rsp_valid && (rsp_status == STATUS_FULL ||
                                      rsp_status == STATUS_NOT_FOUND);
   assign rsp_payload = {rsp_status, rsp_slot};

   // reset starts the clearing pass with no result pending
   `DHT_ASSERT_ALWAYS(a_reset_busy, reset |=> (req_stall && !rsp_valid), "not busy after reset")

   // a waiting result keeps its payload
   `DHT_ASSERT(a_rsp_hold, rsp_wait |=> (rsp_valid && $stable(rsp_payload)), "stalled item changed")

   // misses report slot zero
   `DHT_ASSERT(a_miss_slot, rsp_miss |-> (rsp_slot == '0), "miss with non-zero slot")

   // an accepted item keeps the block busy on the next cycle
   `DHT_ASSERT(a_one_item, (req_valid && !req_stall) |=> req_stall, "second item taken while busy")

endmodule

bind double_hash_table dht_checker u_dht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_slot   (rsp_slot)
);

`default_nettype wire

@@ tb/sv/double_hash_table_checker.sv @@
// ----------------------------------------------------------------------------
// double_hash_table_checker
// Watches both channels of the double-hashing table, keeps its own copy of
// the slot memory, works out the lookup result of every accepted item and
// compares it with the results that leave the block, oldest first.
// ----------------------------------------------------------------------------

module double_hash_table_checker
   import dht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic                  req_mode,
   input  wire logic [KEY_W-1:0]      req_key,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [1:0]            rsp_status,
   input  wire logic [SLOT_OUT_W-1:0] rsp_slot,
   output int                         failures,
   output int                         outstanding
);

   typedef struct packed {
      status_type            status;
      logic [SLOT_OUT_W-1:0] slot;
   } lookup_result_type;

   logic [KEY_W-1:0]  slot_key  [TABLE_SIZE];
   bit                slot_full [TABLE_SIZE];
   lookup_result_type pending_lookups [$];
   int                mismatch_cnt = 0;
   int                result_cnt   = 0;

   // Walk the probe path of one key and apply an insert to the slot copy.
   function automatic lookup_result_type probe_table(input logic mode,
                                                     input logic [KEY_W-1:0] key);
      int unsigned       home;
      int unsigned       stride;
      int unsigned       pos;
      lookup_result_type res;
      home   = key % TABLE_SIZE;
      stride = STEP_BASE - key % STEP_BASE;
      res.slot = '0;
      if (mode == MODE_INSERT) begin
         res.status = STATUS_FULL;
      end else begin
         res.status = STATUS_NOT_FOUND;
      end
      for (int n = 0; n < TABLE_SIZE; n++) begin
         pos = (home + n * stride) % TABLE_SIZE;
         if (!slot_full[pos]) begin
            if (mode == MODE_INSERT) begin
               slot_full[pos] = 1'b1;
               slot_key[pos]  = key;
               res.status     = STATUS_INSERTED;
               res.slot       = pos[SLOT_OUT_W-1:0];
            end
            break;
         end
         if (mode == MODE_SEARCH && slot_key[pos] == key) begin
            res.status = STATUS_FOUND;
            res.slot   = pos[SLOT_OUT_W-1:0];
            break;
         end
      end
      return res;
   endfunction

   function automatic void note_failure(input string what);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
         $display("%0t: result %0d: %s", $realtime, result_cnt, what);
      end
   endfunction

   always @(posedge clock) begin : watch
      lookup_result_type want;
      if (reset) begin
         foreach (slot_full[i]) slot_full[i] = 1'b0;
         pending_lookups.delete();
      end else begin
         // Compare first, so a result never meets the item accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            result_cnt++;
            if (pending_lookups.size() == 0) begin
               note_failure($sformatf("unexpected result status %0d slot %0d",
                                      rsp_status, rsp_slot));
            end else begin
               want = pending_lookups.pop_front();
               if (rsp_status !== want.status || rsp_slot !== want.slot) begin
                  note_failure($sformatf(
                     "expected status %0d slot %0d, got status %0d slot %0d",
                     want.status, want.slot, rsp_status, rsp_slot));
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_lookups.push_back(probe_table(req_mode, req_key));
         end
      end
      outstanding <= pending_lookups.size();
      failures    <= mismatch_cnt;
   end

endmodule

@@ tb/sv/double_hash_table_test.sv @@
// ----------------------------------------------------------------------------
// double_hash_table_test
// Drives inserts and searches into the double-hashing table and gives the
// verdict. A short directed sequence fills the even slots to reach table full
// and exhausted searches while most odd slots stay empty; random traffic follows,
// with idle bursts on both channels. Checking is done by the checker module.
// ----------------------------------------------------------------------------

module double_hash_table_test
   import dht_pkg::*;
;

   localparam int TABLE_SIZE = TABLE_SIZE_DEF;
   localparam int N_RANDOM   = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_mode;
   logic [KEY_W-1:0]      req_key;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot;

   int failures;
   int outstanding;

   // Quiet phases: no idling on either channel while this is set.
   bit calm = 1'b0;

   // Every key offered for insertion, kept so that searches can hit it.
   logic [KEY_W-1:0] inserted_keys [$];

   double_hash_table #(
      .TABLE_SIZE (TABLE_SIZE)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

   double_hash_table_checker #(
      .TABLE_SIZE (TABLE_SIZE)
   ) table_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_key     (req_key),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_slot    (rsp_slot),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Build a key with a chosen home slot and a chosen remainder mod 7 (which
   // fixes the probe stride), lifted by a random multiple of the joint period
   // so that the upper key bits get exercised too.
   function automatic logic [KEY_W-1:0] compose_key(input int home, input int rem);
      int unsigned period;
      int unsigned base;
      int unsigned upper;
      period = TABLE_SIZE * STEP_BASE;
      base   = 0;
      while (base % TABLE_SIZE != home || base % STEP_BASE != rem) base++;
      upper = $urandom_range(0, (32'h7FFF_FFFF - period) / period);
      return KEY_W'(base + period * upper);
   endfunction

   // Present one item at the falling edge and hold it until accepted.
   task automatic send_item(input logic mode, input logic [KEY_W-1:0] key);
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      do @(posedge clock); while (req_stall);
      if (mode == MODE_INSERT) inserted_keys.push_back(key);
   endtask

   // Drop valid and hold off until every expected result has come back.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Result side: stall in random bursts, none during the quiet phases.
   initial begin : rsp_side
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] pick;
      logic [31:0]      rnd;
      logic             op;
      int               roll;
      int               gap;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_mode  = MODE_INSERT;
      req_key   = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // --- directed part -----------------------------------------------------
      // Search an empty table, then insert the smallest and largest keys and
      // a duplicate of key 0, which has to move on along its probe path.
      send_item(MODE_SEARCH, '0);
      send_item(MODE_INSERT, '0);
      send_item(MODE_INSERT, {KEY_W{1'b1}});
      send_item(MODE_INSERT, '0);
      send_item(MODE_SEARCH, '0);
      send_item(MODE_SEARCH, {KEY_W{1'b1}});
      // Same home as key 0 but a different key: step past it to an empty slot.
      send_item(MODE_SEARCH, compose_key(0, 2));

      // Fill every even slot (stride 7 lands on the empty home at once).
      for (int h = 2; h < TABLE_SIZE; h += 2) send_item(MODE_INSERT, compose_key(h, 0));

      // Even strides from an even home only ever see even slots: table full
      // on insert and an exhausted probe path on search, though some odd slots
      // are still free.
      send_item(MODE_INSERT, compose_key(4, 5));
      send_item(MODE_INSERT, compose_key(6, 3));
      send_item(MODE_SEARCH, compose_key(6, 5));
      send_item(MODE_SEARCH, compose_key(2, 3));
      send_item(MODE_SEARCH, inserted_keys[3]);
      // Odd home, stride 6: lands in a free odd slot.
      send_item(MODE_INSERT, compose_key(1, 1));

      drain;

      // --- random part -------------------------------------------------------
      // Inserts are kept rare so that the table fills gradually and searches
      // meet both empty slots and, later, exhausted probe paths.
      for (int i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 150 && i < 200) || i >= N_RANDOM - 60;
         roll = $urandom_range(0, 99);
         rnd  = $urandom;
         pick = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
         if (roll < 15) begin
            op = MODE_INSERT;
            case ($urandom_range(0, 3))
               0, 1: key = rnd[KEY_W-1:0];
               2: key = pick;
               default: key = compose_key($urandom_range(0, TABLE_SIZE - 1),
                                          $urandom_range(0, STEP_BASE - 1));
            endcase
         end else if (roll < 55) begin
            op  = MODE_SEARCH;
            key = pick;
         end else if (roll < 75) begin
            // Alias of a stored key: same probe path, different key.
            op  = MODE_SEARCH;
            key = compose_key(pick % TABLE_SIZE, pick % STEP_BASE);
         end else begin
            op  = MODE_SEARCH;
            key = rnd[KEY_W-1:0];
         end
         send_item(op, key);

         if (i % 100 == 50) begin
            drain;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            // Idle burst: drop valid and scramble the idle payload.
            gap = $urandom_range(1, 18);
            rnd = $urandom;
            @(negedge clock);
            req_valid <= 1'b0;
            req_mode  <= rnd[31];
            req_key   <= rnd[KEY_W-1:0];
            repeat (gap - 1) @(negedge clock);
         end
      end

      // Wait out the last results, then allow a full probe walk for strays.
      drain;
      repeat (2 * TABLE_SIZE + 16) @(posedge clock);
      if (failures == 0) begin
         $display("double_hash_table test passed");
      end else begin
         $display("double_hash_table test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("double_hash_table test failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/dht_pkg.sv
src/dht_dpath.sv
src/dht_ctrl.sv
src/double_hash_table.sv
src/dht_checker.sv
tb/sv/double_hash_table_checker.sv
tb/sv/double_hash_table_test.sv
